// ===== rtl/fstp_pkg.sv =====
// Shared types and constants for the fixed-timestep frame pacer.
// No dependencies; imported by every other design file except fstp_checker.
package fstp_pkg;

    localparam int ACC_W   = 40;
    localparam int CNT_W   = 64;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 40;
    localparam int ITER_W  = 6;
    localparam int PROD_W  = 60;

    // frames/s in 1/256 units: frames * 1e6 us/s * 256
    localparam logic [27:0] RATE_SCALE = 28'd256000000;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // step division: 40-bit dividend left aligned, 40 iterations
    localparam logic [ITER_W-1:0] STEP_ITERS = 6'd40;
    // rate division: 60-bit product left aligned, 60 iterations
    localparam logic [ITER_W-1:0] RATE_ITERS = 6'd60;

    typedef enum logic [1:0] {
        REG_STEP_PERIOD = 2'd0,
        REG_MAX_FRAME   = 2'd1,
        REG_MAX_STEPS   = 2'd2,
        REG_RATE_WINDOW = 2'd3
    } cfg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture raw delta, clamp, bump frame and uptime
        logic accum;     // add delta to step and window accumulators
        logic step_div;  // start accumulator / period
        logic take_n;    // pick step count from quotient or cap
        logic mul_np;    // n * period
        logic sub_np;    // retire released steps
        logic rate_mul;  // window frames * scale
        logic rate_div;  // start product / window time
        logic rate_sat;  // store saturated quotient, clear window
        logic rate_ff;   // empty window closed: all ones, clear window
        logic out_load;  // copy results into output register
    } fstp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_busy;
        logic period_zero;
        logic win_close;
        logic wt_zero;
    } fstp_stat_t;

endpackage

// ===== rtl/fstp_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses fstp_pkg widths; instantiated by fstp_dpath.
module fstp_div
    import fstp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_N_W-1:0]   dividend,
    input  logic [DIV_D_W-1:0]   divisor,
    input  logic [ITER_W-1:0]    iters,
    output logic                 busy,
    output logic [DIV_N_W-1:0]   quotient
);

    logic                busy_reg, busy_next;
    logic [ITER_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]  rem_reg, rem_next;
    logic [DIV_N_W-1:0]  quo_reg, quo_next;
    logic [DIV_D_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_D_W:0]    trial;
    logic [DIV_D_W:0]    diff;
    logic                ge;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = iters;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/fstp_dpath.sv =====
// Datapath: configuration, accumulators, counters, shared divider, output register.
// Depends on fstp_pkg and fstp_div.
module fstp_dpath
    import fstp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [31:0]        cfg_wdata,
    input  logic [31:0]        s_raw_delta,
    input  fstp_cmd_t          cmd,
    output fstp_stat_t         stat,
    output logic [31:0]        m_frame_delta,
    output logic [7:0]         m_pending_steps,
    output logic [63:0]        m_frame_total,
    output logic [63:0]        m_step_total,
    output logic [63:0]        m_uptime,
    output logic [31:0]        m_frame_rate
);

    // configuration
    logic [19:0] period_reg;
    logic [31:0] max_frame_reg;
    logic [7:0]  max_steps_reg;
    logic [23:0] window_reg;

    // running state
    logic [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0] frames_reg;
    logic [CNT_W-1:0] steps_reg;
    logic [CNT_W-1:0] elapsed_reg;
    logic [ACC_W-1:0] wtime_reg;
    logic [31:0]      wframes_reg;
    logic [31:0]      rate_reg;

    // per-item scratch
    logic [31:0]       delta_reg;
    logic [7:0]        n_reg;
    logic [27:0]       np_reg;
    logic [PROD_W-1:0] prod_reg;

    // output register
    logic [31:0] o_delta_reg;
    logic [7:0]  o_steps_reg;
    logic [63:0] o_frames_reg;
    logic [63:0] o_stotal_reg;
    logic [63:0] o_uptime_reg;
    logic [31:0] o_rate_reg;

    logic [ACC_W:0]     acc_sum;
    logic [ACC_W:0]     wt_sum;
    logic [ACC_W-1:0]   acc_sat;
    logic [ACC_W-1:0]   wt_sat;
    logic [7:0]         n_pick;
    logic               div_busy;
    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [ITER_W-1:0]  div_iters;
    logic [DIV_N_W-1:0] div_quo;

    assign acc_sum = {1'b0, acc_reg} + {9'b0, delta_reg};
    assign wt_sum  = {1'b0, wtime_reg} + {9'b0, delta_reg};
    assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    assign wt_sat  = wt_sum[ACC_W] ? ACC_MAX : wt_sum[ACC_W-1:0];

    always_comb begin
        if (period_reg == '0) begin
            n_pick = max_steps_reg;
        end else if ((div_quo[39:8] != '0) || (div_quo[7:0] > max_steps_reg)) begin
            n_pick = max_steps_reg;
        end else begin
            n_pick = div_quo[7:0];
        end
    end

    assign div_start    = cmd.step_div | cmd.rate_div;
    assign div_dividend = cmd.rate_div ? {prod_reg, 4'b0} : {acc_reg, 24'b0};
    assign div_divisor  = cmd.rate_div ? wtime_reg : {20'b0, period_reg};
    assign div_iters    = cmd.rate_div ? RATE_ITERS : STEP_ITERS;

    fstp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= 20'd16667;
            max_frame_reg <= 32'd250000;
            max_steps_reg <= 8'd5;
            window_reg    <= 24'd500000;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_idx))
                REG_STEP_PERIOD: period_reg    <= cfg_wdata[19:0];
                REG_MAX_FRAME:   max_frame_reg <= cfg_wdata;
                REG_MAX_STEPS:   max_steps_reg <= cfg_wdata[7:0];
                REG_RATE_WINDOW: window_reg    <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            frames_reg  <= '0;
            steps_reg   <= '0;
            elapsed_reg <= '0;
            wtime_reg   <= '0;
            wframes_reg <= '0;
            rate_reg    <= '0;
        end else begin
            if (cmd.load_in) begin
                frames_reg  <= frames_reg + 64'd1;
                elapsed_reg <= elapsed_reg + {32'b0, s_raw_delta};
            end
            if (cmd.accum) begin
                acc_reg   <= acc_sat;
                wtime_reg <= wt_sat;
                if (wframes_reg != '1) begin
                    wframes_reg <= wframes_reg + 32'd1;
                end
            end
            if (cmd.sub_np) begin
                acc_reg   <= acc_reg - {12'b0, np_reg};
                steps_reg <= steps_reg + {56'b0, n_reg};
            end
            if (cmd.rate_sat) begin
                rate_reg    <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
                wtime_reg   <= '0;
                wframes_reg <= '0;
            end
            if (cmd.rate_ff) begin
                rate_reg    <= '1;
                wtime_reg   <= '0;
                wframes_reg <= '0;
            end
        end
    end

    // scratch and output payload
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            delta_reg <= (s_raw_delta < max_frame_reg) ? s_raw_delta : max_frame_reg;
        end
        if (cmd.take_n) begin
            n_reg <= n_pick;
        end
        if (cmd.mul_np) begin
            np_reg <= {20'b0, n_reg} * {8'b0, period_reg};
        end
        if (cmd.rate_mul) begin
            prod_reg <= {28'b0, wframes_reg} * {32'b0, RATE_SCALE};
        end
        if (cmd.out_load) begin
            o_delta_reg  <= delta_reg;
            o_steps_reg  <= n_reg;
            o_frames_reg <= frames_reg;
            o_stotal_reg <= steps_reg;
            o_uptime_reg <= elapsed_reg;
            o_rate_reg   <= rate_reg;
        end
    end

    assign stat.div_busy    = div_busy;
    assign stat.period_zero = (period_reg == '0);
    assign stat.win_close   = (wtime_reg >= {16'b0, window_reg});
    assign stat.wt_zero     = (wtime_reg == '0);

    assign m_frame_delta   = o_delta_reg;
    assign m_pending_steps = o_steps_reg;
    assign m_frame_total   = o_frames_reg;
    assign m_step_total    = o_stotal_reg;
    assign m_uptime        = o_uptime_reg;
    assign m_frame_rate    = o_rate_reg;

endmodule

// ===== rtl/fstp_ctrl.sv =====
// Sequencer for one frame item: accumulate, step division, rate window, output.
// Depends on fstp_pkg command and status structs.
module fstp_ctrl
    import fstp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  fstp_stat_t stat,
    output fstp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_TAKE_N,
        ST_MUL,
        ST_SUB,
        ST_RATE_CHK,
        ST_RATE_MUL,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_RATE_END,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_STEP_GO;
            end
            ST_STEP_GO: begin
                if (stat.period_zero) begin
                    state_next = ST_TAKE_N;
                end else begin
                    cmd.step_div = 1'b1;
                    state_next   = ST_STEP_WAIT;
                end
            end
            ST_STEP_WAIT: begin
                if (!stat.div_busy) state_next = ST_TAKE_N;
            end
            ST_TAKE_N: begin
                cmd.take_n = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_np = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                cmd.sub_np = 1'b1;
                state_next = ST_RATE_CHK;
            end
            ST_RATE_CHK: begin
                if (!stat.win_close) begin
                    state_next = ST_OUT;
                end else if (stat.wt_zero) begin
                    cmd.rate_ff = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    state_next = ST_RATE_MUL;
                end
            end
            ST_RATE_MUL: begin
                cmd.rate_mul = 1'b1;
                state_next   = ST_RATE_GO;
            end
            ST_RATE_GO: begin
                cmd.rate_div = 1'b1;
                state_next   = ST_RATE_WAIT;
            end
            ST_RATE_WAIT: begin
                if (!stat.div_busy) state_next = ST_RATE_END;
            end
            ST_RATE_END: begin
                cmd.rate_sat = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/fixed_timestep_frame_pacer_unit.sv =====
// Top level of the fixed-timestep frame pacer: controller plus datapath.
// Depends on fstp_pkg, fstp_ctrl, fstp_dpath (which holds fstp_div).
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | s_valid / s_ready   | s_raw_delta[31:0]
//  result   | m_valid / m_ready   | m_frame_delta, m_pending_steps,
//           |                     | m_frame_total, m_step_total, m_uptime,
//           |                     | m_frame_rate
//  config   | cfg_we (no wait)    | cfg_idx[1:0], cfg_wdata[31:0]
//
// One item at a time. Each item computes accumulator/period in 40 iterations of
// the shared radix-2 divider; with a zero step period the division is skipped.
// When the rate window closes the same divider runs 60 more iterations for
// frames*256e6/window_time, or gives all ones if the window time is zero.
// Reset (aresetn low, synchronous) restores default config and zeroes all
// counters and accumulators. A finished result sits in the output register;
// the next item is accepted while it waits, and processing stalls only at
// the final load step if the previous result has not yet been taken.
module fixed_timestep_frame_pacer_unit
    import fstp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_wdata,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_raw_delta,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_frame_delta,
    output logic [7:0]  m_pending_steps,
    output logic [63:0] m_frame_total,
    output logic [63:0] m_step_total,
    output logic [63:0] m_uptime,
    output logic [31:0] m_frame_rate
);

    fstp_cmd_t  cmd;
    fstp_stat_t stat;

    // sequencer: walks each frame through its phases
    fstp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic, state and output register
    fstp_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_wdata       (cfg_wdata),
        .s_raw_delta     (s_raw_delta),
        .cmd             (cmd),
        .stat            (stat),
        .m_frame_delta   (m_frame_delta),
        .m_pending_steps (m_pending_steps),
        .m_frame_total   (m_frame_total),
        .m_step_total    (m_step_total),
        .m_uptime        (m_uptime),
        .m_frame_rate    (m_frame_rate)
    );

endmodule

// ===== rtl/fstp_checker.sv =====
// Port-level checks for the frame pacer, bound onto the top level.
// Depends only on the top level's port list.
module fstp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic [1:0]  cfg_idx,
    input logic [31:0] cfg_wdata,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_raw_delta,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_frame_delta,
    input logic [7:0]  m_pending_steps,
    input logic [63:0] m_frame_total,
    input logic [63:0] m_step_total,
    input logic [63:0] m_uptime,
    input logic [31:0] m_frame_rate
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_total)
            && $stable(m_step_total) && $stable(m_frame_rate))
        else $error("result changed while stalled");

    // reset leaves no result pending and the input open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

    // an accepted item keeps the input closed in ST_ACCUM and ST_STEP_GO, the states after acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input reopened too early");

endmodule

bind fixed_timestep_frame_pacer_unit fstp_checker u_fstp_checker (.*);
